@@ rtl/core/modular_inverse_ext_euclid_top_macros.svh @@
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression that must never be true outside reset
`define MIE_ASSERT_NEVER(lbl, expr, msg) \
  `MIE_ASSERT(lbl, !(expr), msg)
`else
`define MIE_ASSERT(lbl, prop, msg)
`define MIE_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/core/mie_pkg.sv @@
// Package: widths, reset value and control structs of the modular inverse block.
`default_nettype none
package mie_pkg;

  localparam int WORD_BITS     = 32;
  localparam int CNT_W         = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] RESET_MODULUS = WORD_BITS'(998244353);

  typedef logic [WORD_BITS-1:0] word_t;

  // sequencer -> divide unit
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // divide unit -> sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/mie_ifs.sv @@
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none
interface mie_in_if;
  logic                 valid;
  logic                 ready;
  logic [mie_pkg::WORD_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mie_out_if;
  logic                 valid;
  logic                 ready;
  logic [mie_pkg::WORD_BITS-1:0] inverse;
  logic                 no_inverse;
  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

interface mie_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [mie_pkg::WORD_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mie_divstep.sv @@
// Shared divide unit: restoring division, one quotient bit per cycle, with q*mult accumulate.
`default_nettype none
`include "modular_inverse_ext_euclid_top_macros.svh"
module mie_divstep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mie_pkg::div_ctl_t ctl,
  input  wire mie_pkg::word_t    dividend,
  input  wire mie_pkg::word_t    divisor,
  input  wire mie_pkg::word_t    mult,
  output mie_pkg::div_sts_t      sts,
  output mie_pkg::word_t         rem,
  output mie_pkg::word_t         prod
);

  localparam int W = mie_pkg::WORD_BITS;

  mie_pkg::word_t          num_r, div_r, mult_r, rem_r, acc_r;
  logic [mie_pkg::CNT_W-1:0] cnt_r;
  logic                    busy_r, done_r;

  logic [W:0]     rem_sh, div_ext, diff;
  logic           ge;
  mie_pkg::word_t acc_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[W-1]};
    div_ext = {1'b0, div_r};
    diff    = rem_sh - div_ext;
    ge      = (rem_sh >= div_ext);
    // Horner form: acc = acc*2 + bit*mult gives q*mult after the last bit
    acc_nxt = {acc_r[W-2:0], 1'b0} + (ge ? mult_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= mie_pkg::CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - mie_pkg::CNT_W'(1);
        if (cnt_r == mie_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r  <= dividend;
      div_r  <= divisor;
      mult_r <= mult;
      rem_r  <= '0;
      acc_r  <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[W-2:0], 1'b0};
      rem_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      acc_r <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;
  assign prod     = acc_r;

  `MIE_ASSERT_NEVER(a_start_busy, ctl.start && busy_r, "divide started while busy")
  `MIE_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "done without a running divide")
  `MIE_ASSERT(a_rem_below_div, done_r |-> (rem_r < div_r), "remainder not below divisor")

endmodule
`default_nettype wire

@@ rtl/core/modular_inverse_ext_euclid_top.sv @@
// Top level: modular inverse by extended Euclid on a shared divide unit.
// Usage:
//   cfg_ch: write word = modulus (reset 998244353). Always ready; write only
//   while no item is in flight.
//   in_ch: one word = value. Taken when valid and ready are high; ready is
//   high only while the sequencer is idle.
//   out_ch: one word per input = inverse in 0..modulus-1 and no_inverse.
//   no_inverse is set, with inverse 0, when gcd(value, modulus) != 1 or the
//   modulus is zero.
// Sequence: one reduction of value plus one divide per Euclid step on the
//   bit-serial divider; steps is at most about 1.44 * WORD_BITS.
// Throughput: one item at a time; the next value is taken as soon as the
//   result sits in the output register.
// Stall: a finished result holds in the output register; if the previous one
//   is still untaken, the sequencer waits in its final state.
// Reset: synchronous active-low rst_n clears control state and restores the
//   modulus; no clearing pass.
`default_nettype none
`include "modular_inverse_ext_euclid_top_macros.svh"
module modular_inverse_ext_euclid_top (
  input  wire logic clk,
  input  wire logic rst_n,
  mie_cfg_if.sink   cfg_ch,
  mie_in_if.sink    in_ch,
  mie_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_INITW = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_STEPW = 3'd4;
  localparam logic [2:0] S_NORM  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;

  mie_pkg::word_t mod_r, m_r, r_prev_r, r_cur_r, u_prev_r, u_cur_r;
  logic           neg_prev_r, neg_cur_r;
  logic           out_valid_r;
  mie_pkg::word_t out_inv_r;
  logic           out_none_r;

  mie_pkg::div_ctl_t div_ctl;
  mie_pkg::div_sts_t div_sts;
  mie_pkg::word_t    div_dividend, div_divisor, div_rem, div_prod;

  logic           in_fire, out_load, fin_none;
  mie_pkg::word_t fin_inv;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    div_ctl.start = (state_r == S_INIT) || ((state_r == S_CHECK) && (r_cur_r != '0));
    // first divide reduces value mod modulus, later ones run the remainder sequence
    div_dividend  = (state_r == S_INIT) ? r_cur_r : r_prev_r;
    div_divisor   = (state_r == S_INIT) ? r_prev_r : r_cur_r;
  end

  mie_divstep u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .mult     (u_cur_r),
    .sts      (div_sts),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  always_comb begin
    fin_none = (r_prev_r != mie_pkg::WORD_BITS'(1));
    if (fin_none) begin
      fin_inv = '0;
    end else if (neg_prev_r && (u_prev_r != '0)) begin
      fin_inv = m_r - u_prev_r;
    end else begin
      fin_inv = u_prev_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = (mod_r == '0) ? S_FIN : S_INIT;
      S_INIT:  state_nxt = S_INITW;
      S_INITW: if (div_sts.done) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (r_cur_r == '0) ? S_NORM : S_STEPW;
      S_STEPW: if (div_sts.done) state_nxt = S_CHECK;
      S_NORM:  state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= mie_pkg::RESET_MODULUS;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) mod_r <= cfg_ch.data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          m_r      <= mod_r;
          r_prev_r <= mod_r;
          r_cur_r  <= in_ch.value;
        end
      end
      S_INITW: begin
        if (div_sts.done) begin
          r_cur_r    <= div_rem;
          u_prev_r   <= '0;
          u_cur_r    <= mie_pkg::WORD_BITS'(1);
          neg_prev_r <= 1'b0;
          neg_cur_r  <= 1'b0;
        end
      end
      S_STEPW: begin
        if (div_sts.done) begin
          r_prev_r   <= r_cur_r;
          r_cur_r    <= div_rem;
          u_prev_r   <= u_cur_r;
          u_cur_r    <= u_prev_r + div_prod;
          neg_prev_r <= neg_cur_r;
          neg_cur_r  <= !neg_cur_r;
        end
      end
      S_NORM: begin
        // coefficient magnitude never exceeds the modulus: one subtract reduces it
        if (u_prev_r >= m_r) u_prev_r <= u_prev_r - m_r;
      end
      default: ;
    endcase
    if (out_load) begin
      out_inv_r  <= fin_inv;
      out_none_r <= fin_none;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inverse    = out_inv_r;
  assign out_ch.no_inverse = out_none_r;

  `MIE_ASSERT(a_busy_after_accept, in_fire |=> (state_r != S_IDLE), "item accepted but idle")
  `MIE_ASSERT(a_none_zero, (out_valid_r && out_none_r) |-> (out_inv_r == '0),
              "no_inverse with nonzero inverse")
  `MIE_ASSERT(a_done_in_wait, div_sts.done |-> (state_r == S_INITW || state_r == S_STEPW),
              "divide done outside a wait state")
  `MIE_ASSERT(a_busy_in_wait, div_sts.busy |-> (state_r == S_INITW || state_r == S_STEPW),
              "divide running outside a wait state")

endmodule
`default_nettype wire

@@ bench/modular_inverse_ext_euclid_checker.sv @@
// Checker: watches the three channels, predicts each inverse and compares result words.
`timescale 1ns / 1ps
module modular_inverse_ext_euclid_checker (
  input  logic clk,
  input  logic rst_n,
  mie_cfg_if   cfg_mon,
  mie_in_if    in_mon,
  mie_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    mie_pkg::word_t inverse;
    logic           no_inverse;
  } inv_word_t;

  mie_pkg::word_t modulus_q;
  inv_word_t      expected_inv_q[$];
  int             fails = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Extended Euclid with the Bezout coefficient held as magnitude plus sign
  function automatic inv_word_t predict_inverse(input mie_pkg::word_t value,
                                                input mie_pkg::word_t modulus);
    logic [63:0] r_prev, r_cur, r_next, u_prev, u_cur, u_next, quot;
    logic        neg_prev, neg_cur;
    inv_word_t   res;
    res = '0;
    if (modulus == '0) begin
      res.no_inverse = 1'b1;
      return res;
    end
    r_prev   = 64'(modulus);
    r_cur    = 64'(value % modulus);
    u_prev   = 64'd0;
    u_cur    = 64'd1;
    neg_prev = 1'b0;
    neg_cur  = 1'b0;
    while (r_cur != 64'd0) begin
      quot     = r_prev / r_cur;
      r_next   = r_prev - quot * r_cur;
      u_next   = u_prev + quot * u_cur;
      r_prev   = r_cur;
      r_cur    = r_next;
      u_prev   = u_cur;
      u_cur    = u_next;
      neg_prev = neg_cur;
      neg_cur  = !neg_cur;
    end
    if (r_prev != 64'd1) begin
      res.no_inverse = 1'b1;
      return res;
    end
    u_prev = u_prev % 64'(modulus);
    if (neg_prev && u_prev != 64'd0)
      res.inverse = mie_pkg::word_t'(64'(modulus) - u_prev);
    else
      res.inverse = mie_pkg::word_t'(u_prev);
    return res;
  endfunction

  always @(posedge clk) begin : watch_words
    inv_word_t got;
    inv_word_t want;
    if (!rst_n) begin
      modulus_q = mie_pkg::RESET_MODULUS;
      expected_inv_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.inverse    = out_mon.inverse;
        got.no_inverse = out_mon.no_inverse;
        if (expected_inv_q.size() == 0) begin
          $error("result word with nothing expected: inverse %h no_inverse %b",
                 got.inverse, got.no_inverse);
          fails++;
        end else begin
          want = expected_inv_q.pop_front();
          if (got.inverse !== want.inverse) begin
            $error("inverse mismatch: expected %h, actual %h", want.inverse, got.inverse);
            fails++;
          end
          if (got.no_inverse !== want.no_inverse) begin
            $error("no_inverse mismatch: expected %b, actual %b",
                   want.no_inverse, got.no_inverse);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_inv_q.push_back(predict_inverse(in_mon.value, modulus_q));
      // modulus only changes while idle, so it applies to later words
      if (cfg_mon.valid && cfg_mon.ready)
        modulus_q = cfg_mon.data;
    end
    fail_count <= fails;
    pending    <= expected_inv_q.size();
  end

endmodule

@@ bench/modular_inverse_ext_euclid_top_test.sv @@
// Testbench top: drives values and modulus writes into the inverse block and gives the verdict.
`timescale 1ns / 1ps
module modular_inverse_ext_euclid_top_test;

  localparam int LIMIT_CYCLES   = 3000000;
  localparam int TAIL_CYCLES    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SEGMENTS       = 9;
  localparam int SEGMENT_VALUES = 44;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  mie_cfg_if cfg_ch ();
  mie_in_if  in_ch ();
  mie_out_if out_ch ();

  modular_inverse_ext_euclid_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  modular_inverse_ext_euclid_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_mon    (cfg_ch),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // starts at the negedge after the previous word, so valid moves once per step
  task automatic push_value(input mie_pkg::word_t value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input mie_pkg::word_t modulus);
    drain_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= modulus;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic mie_pkg::word_t random_value(input mie_pkg::word_t modulus);
    mie_pkg::word_t v;
    case ($urandom_range(9))
      5:       v = $urandom_range(255);
      6:       v = modulus + $urandom_range(8) - 4;
      7:       v = modulus * $urandom_range(3);
      8:       v = $urandom & 32'hFFFF_FF00;
      9:       v = 32'hFFFF_FFFF - $urandom_range(16);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic mie_pkg::word_t segment_modulus(input int seg);
    mie_pkg::word_t m;
    case (seg)
      0:       m = mie_pkg::RESET_MODULUS;
      1:       m = 32'hFFFF_FFFF;
      2:       m = 32'd2;
      3:       m = $urandom;
      4:       m = $urandom_range(1000, 3);
      5:       m = 32'h8000_0000;
      6:       m = 32'd1000000007;
      7:       m = 32'd3;
      default: m = $urandom_range(32'hFFFF, 2) * 6;
    endcase
    return m;
  endfunction

  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 75;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset modulus: edges, multiples and values past the modulus
    push_value(32'd0);
    push_value(32'd1);
    push_value(32'd2);
    push_value(mie_pkg::RESET_MODULUS - 1);
    push_value(mie_pkg::RESET_MODULUS);
    push_value(mie_pkg::RESET_MODULUS + 1);
    push_value(mie_pkg::RESET_MODULUS * 2);
    push_value(32'h8000_0000);
    push_value(32'hFFFF_FFFF);

    // modulus zero: never invertible
    write_modulus(32'd0);
    push_value(32'd5);
    push_value(32'd0);

    // modulus one: everything inverts to zero
    write_modulus(32'd1);
    push_value(32'd0);
    push_value(32'd7);
    push_value(32'hFFFF_FFFF);

    write_modulus(32'd2);
    push_value(32'd0);
    push_value(32'd1);
    push_value(32'd3);

    // all-ones modulus is 3*5*17*257*65537
    write_modulus(32'hFFFF_FFFF);
    push_value(32'hFFFF_FFFE);
    push_value(32'd3);
    push_value(32'd2);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mie_pkg::word_t m;
      case (seg / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      m = segment_modulus(seg);
      write_modulus(m);
      repeat (SEGMENT_VALUES) push_value(random_value(m));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
